// File: design/vde_pkg.sv
// Package with shared types, constants and metric codes for the vector distance engine.
`default_nettype none
package vde_pkg;

  localparam int unsigned MaxLenDefault    = 1024;
  localparam int unsigned ElemWidthDefault = 16;
  localparam int unsigned FieldWidth       = 16;
  localparam int unsigned DistWidth        = 44;
  localparam int unsigned SumWidth         = 48;
  localparam int unsigned NormWidth        = 43;

  typedef enum logic [1:0] {
    METRIC_EUCLID  = 2'd0,
    METRIC_SQ      = 2'd1,
    METRIC_MANH    = 2'd2,
    METRIC_COSINE  = 2'd3
  } metric_e;

  typedef struct packed {
    logic signed [FieldWidth-1:0] a_element;
    logic signed [FieldWidth-1:0] b_element;
    logic                         last_element;
  } in_beat_t;

  typedef struct packed {
    logic signed [DistWidth-1:0] distance;
    logic                        zero_norm;
    logic                        saturated;
  } out_beat_t;

  // One finished vector handed from the accumulator to the finishing unit.
  typedef struct packed {
    metric_e                      metric;
    logic signed [SumWidth-1:0]   main_sum;
    logic        [NormWidth-1:0]  norm_a;
    logic        [NormWidth-1:0]  norm_b;
    logic                         sat;
  } job_t;

endpackage
`default_nettype wire

// File: design/vde_front.sv
// Front end: accumulates element pairs and queues one job per finished vector.
`default_nettype none
module vde_front import vde_pkg::*; #(
  parameter int unsigned MaxLen    = MaxLenDefault,
  parameter int unsigned ElemWidth = ElemWidthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire metric_e  metric_i,
  input  wire in_beat_t in_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output job_t          job_o,
  output logic          job_valid_o,
  input  wire logic     job_ready_i
);

  localparam int unsigned Ew = (ElemWidth > 16) ? 16 : ElemWidth;
  localparam logic [SumWidth-1:0] Cap =
      ((64'(MaxLen) << 32) < (64'd1 << 42)) ? SumWidth'(64'(MaxLen) << 32)
                                            : SumWidth'(64'd1 << 42);
  localparam int unsigned QDepth = 2;

  // Stage 1: registered products.
  logic                       s1_valid_q, s1_last_q;
  metric_e                    s1_metric_q;
  logic signed [33:0]         s1_main_q;
  logic        [31:0]         s1_na_q, s1_nb_q;

  logic signed [SumWidth-1:0]  acc_q;
  logic        [NormWidth-1:0] na_q, nb_q;
  logic                        sat_q;

  job_t                        fifo_q [QDepth];
  logic [0:0]                  wp_q, rp_q;
  logic [1:0]                  cnt_q;

  logic signed [Ew-1:0] a_s, b_s;
  logic signed [16:0]   d_s;
  logic [16:0]          ad_s;
  logic                 accept;

  always_comb begin
    a_s = in_i.a_element[Ew-1:0];
    b_s = in_i.b_element[Ew-1:0];
    d_s = 17'(a_s) - 17'(b_s);
    ad_s = d_s[16] ? 17'(-d_s) : 17'(d_s);
  end

  // Hold input while the queue plus in-flight item could overflow.
  assign in_ready_o = (32'(cnt_q) + 32'(s1_valid_q && s1_last_q)) < QDepth;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q   <= in_i.last_element;
      s1_metric_q <= metric_i;
      case (metric_i)
        METRIC_MANH:   s1_main_q <= 34'(ad_s);
        METRIC_COSINE: s1_main_q <= 34'(a_s * b_s);
        default:       s1_main_q <= 34'(d_s * d_s);
      endcase
      s1_na_q <= 32'(a_s * a_s);
      s1_nb_q <= 32'(b_s * b_s);
    end
  end

  // Stage 2: saturating accumulate.
  logic signed [SumWidth:0]    m_sum;
  logic        [NormWidth:0]   a_sum, b_sum;
  logic signed [SumWidth-1:0]  m_n;
  logic        [NormWidth-1:0] a_n, b_n;
  logic                        sat_n, cos;

  always_comb begin
    cos   = (s1_metric_q == METRIC_COSINE);
    sat_n = sat_q;
    m_sum = (SumWidth+1)'(acc_q) + (SumWidth+1)'(s1_main_q);
    a_sum = (NormWidth+1)'(na_q) + (NormWidth+1)'(s1_na_q);
    b_sum = (NormWidth+1)'(nb_q) + (NormWidth+1)'(s1_nb_q);
    m_n = m_sum[SumWidth-1:0];
    a_n = na_q;
    b_n = nb_q;
    if (m_sum > $signed({1'b0, Cap})) begin
      m_n = Cap;  sat_n = 1'b1;
    end else if (cos && m_sum < -$signed({1'b0, Cap})) begin
      m_n = -Cap; sat_n = 1'b1;
    end else if (!cos && m_sum < 0) begin
      m_n = '0;   sat_n = 1'b1;
    end
    if (cos) begin
      a_n = a_sum[NormWidth-1:0];
      b_n = b_sum[NormWidth-1:0];
      if (a_sum > (NormWidth+1)'(Cap)) begin a_n = NormWidth'(Cap); sat_n = 1'b1; end
      if (b_sum > (NormWidth+1)'(Cap)) begin b_n = NormWidth'(Cap); sat_n = 1'b1; end
    end
  end

  logic push, pop;
  assign push = s1_valid_q && s1_last_q;
  assign pop  = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; na_q <= '0; nb_q <= '0; sat_q <= 1'b0;
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (s1_valid_q) begin
        if (s1_last_q) begin
          acc_q <= '0; na_q <= '0; nb_q <= '0; sat_q <= 1'b0;
        end else begin
          acc_q <= m_n; na_q <= a_n; nb_q <= b_n; sat_q <= sat_n;
        end
      end
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{metric: s1_metric_q, main_sum: m_n, norm_a: a_n,
                        norm_b: b_n, sat: sat_n};
    end
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rp_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> cnt_q < 2'(QDepth))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && s1_last_q) |=> (acc_q == '0 && !sat_q))
    else $error("accumulators not cleared after last beat");

endmodule
`default_nettype wire

// File: design/vde_back.sv
// Back end: square roots, cosine division and the output register.
`default_nettype none
module vde_back import vde_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire job_t   job_i,
  input  wire logic   job_valid_i,
  output logic        job_ready_o,
  output out_beat_t   out_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQA, S_SQB, S_MUL, S_DIV, S_OUT
  } state_e;

  state_e       state_q;
  job_t         job_q;
  logic [63:0]  rx_q, rr_q, rbit_q;
  logic [31:0]  ra_q;
  logic [63:0]  den_q, rem_q;
  logic [16:0]  q_q;
  logic [5:0]   cnt_q;
  logic [1:0]   mul_step_q;
  out_beat_t    res_q;
  out_beat_t    out_q;
  logic         out_v_q;

  // One step of the digit-by-digit square root.
  logic [63:0] sq_x, sq_r;
  always_comb begin
    sq_x = rx_q;
    sq_r = rr_q >> 1;
    if (rx_q >= rr_q + rbit_q) begin
      sq_x = rx_q - (rr_q + rbit_q);
      sq_r = (rr_q >> 1) + rbit_q;
    end
  end

  logic [63:0] mag, rem_sh;
  always_comb begin
    mag    = job_q.main_sum[SumWidth-1] ? 64'(-job_q.main_sum) : 64'(job_q.main_sum);
    rem_sh = rem_q << 1;
  end

  assign job_ready_o = (state_q == S_IDLE);
  assign out_o       = out_q;
  assign out_valid_o = out_v_q;

  // Product ra*rb is built from two 32x16 partial products.
  logic [47:0] pp;
  assign pp = 48'(ra_q) * 48'(mul_step_q[0] ? rr_q[31:16] : rr_q[15:0]);

  // Append the final quotient bit and clamp to one in Q.16.
  function automatic logic [16:0] fin_q(logic [16:0] q, logic b);
    logic [17:0] t;
    t = {q, b};
    return (q > 17'd32768) ? 17'd65536 : ((t > 18'd65536) ? 17'd65536 : t[16:0]);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      // The output register takes the result register as soon as it frees.
      if (state_q == S_OUT && (!out_v_q || out_ready_i)) begin
        out_v_q <= 1'b1;
        out_q   <= res_q;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            rbit_q <= 64'd1 << 62;
            rr_q   <= '0;
            cnt_q  <= 6'd31;
            case (job_i.metric)
              METRIC_EUCLID: begin
                rx_q <= 64'(job_i.main_sum); state_q <= S_SQB;
              end
              METRIC_COSINE: begin
                if (job_i.norm_a == '0 || job_i.norm_b == '0) begin
                  res_q.distance <= '0; res_q.zero_norm <= 1'b1;
                  res_q.saturated <= job_i.sat; state_q <= S_OUT;
                end else begin
                  rx_q <= 64'(job_i.norm_a) << 16; state_q <= S_SQA;
                end
              end
              default: begin
                res_q.distance <= DistWidth'(job_i.main_sum); res_q.zero_norm <= 1'b0;
                res_q.saturated <= job_i.sat; state_q <= S_OUT;
              end
            endcase
          end
        end
        S_SQA: begin
          rx_q <= sq_x; rr_q <= sq_r; rbit_q <= rbit_q >> 2; cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            ra_q <= 32'(sq_r); rx_q <= 64'(job_q.norm_b) << 16; rr_q <= '0;
            rbit_q <= 64'd1 << 62; cnt_q <= 6'd31; state_q <= S_SQB;
          end
        end
        S_SQB: begin
          rx_q <= sq_x; rr_q <= sq_r; rbit_q <= rbit_q >> 2; cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            if (job_q.metric == METRIC_EUCLID) begin
              res_q.distance <= DistWidth'(sq_r); res_q.zero_norm <= 1'b0;
              res_q.saturated <= job_q.sat; state_q <= S_OUT;
            end else begin
              mul_step_q <= '0; den_q <= '0; state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mul_step_q <= mul_step_q + 1'b1;
          if (mul_step_q[0]) begin
            den_q <= den_q + (64'(pp) << 16);
            rem_q <= mag; q_q <= '0; cnt_q <= 6'd31;
            state_q <= S_DIV;
          end else begin
            den_q <= 64'(pp);
          end
        end
        S_DIV: begin
          if (mag >= den_q) begin
            q_q <= 17'd65536; cnt_q <= '0;
          end
          if (mag >= den_q || cnt_q == '0) begin
            // Final bit folded in here when the loop ends normally.
            state_q <= S_OUT;
            res_q.zero_norm <= 1'b0; res_q.saturated <= job_q.sat;
            if (mag >= den_q) begin
              res_q.distance <= job_q.main_sum[SumWidth-1] ? -DistWidth'(65536)
                                                           : DistWidth'(65536);
            end else begin
              res_q.distance <= job_q.main_sum[SumWidth-1]
                  ? -DistWidth'(fin_q(q_q, rem_sh >= den_q))
                  :  DistWidth'(fin_q(q_q, rem_sh >= den_q));
            end
          end else begin
            // Once the partial quotient reaches one, the final value clamps.
            q_q <= (q_q >= 17'd65536) ? 17'd65537 : {q_q[15:0], rem_sh >= den_q};
            rem_q <= (rem_sh >= den_q) ? rem_sh - den_q : rem_sh;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_OUT: begin
          if (!out_v_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q != S_IDLE) |-> !job_ready_o)
    else $error("job taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("result lost under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_DIV) |-> (den_q != '0))
    else $error("zero divisor in cosine");

endmodule
`default_nettype wire

// File: design/vector_distance_engine.sv
// Top level of the vector distance engine.
//
// Input beats carry one element pair (a_element, b_element, Q8.8) plus
// last_element on a valid/ready channel. The configuration channel writes
// the 2-bit metric: euclidean, squared euclidean, manhattan or cosine.
// The front end takes one beat per cycle while the job queue has room:
// a product stage and a saturating accumulate stage, so a finished vector
// then enters the two-entry job queue, and the accumulators clear at once.
// The back end runs one job at a time: squared euclidean and manhattan go
// straight out, euclidean runs one root of 32 steps, cosine two 32-step
// roots, a two-step multiply, a divider of up to 32 steps, then the output.
// Throughput is one beat per cycle while the back end keeps up with the
// vector length; otherwise input ready drops until a queue entry frees.
// A finished result waits in the output register when the receiver stalls;
// the back end may finish one more job into its result register and then
// holds. Reset clears accumulators, the queue, the metric (euclidean) and
// the output valid. Change the metric only when idle.
`default_nettype none
module vector_distance_engine import vde_pkg::*; #(
  parameter int unsigned MaxLen    = MaxLenDefault,
  parameter int unsigned ElemWidth = ElemWidthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  metric_e metric_q;
  job_t    job;
  logic    job_valid, job_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_EUCLID;
    end else if (cfg_valid_i) begin
      metric_q <= metric_e'(cfg_data_i);
    end
  end

  vde_front #(.MaxLen(MaxLen), .ElemWidth(ElemWidth)) u_front (
    .clk_i, .rst_ni,
    .metric_i(metric_q),
    .in_i(in_data_i), .in_valid_i, .in_ready_o,
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  vde_back u_back (
    .clk_i, .rst_ni,
    .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready),
    .out_o(out_data_o), .out_valid_o, .out_ready_i
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the vector distance engine: random and directed element streams.
`default_nettype none
module tb;
  import vde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SumCap = 64'd1 << 42; // MaxLen 1024 << 32 equals 2^42

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;

  vector_distance_engine u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus queues. A pending beat with cfg_flag set is a metric write instead
  // of an element pair; the driver only issues it once the engine has drained.
  typedef struct {
    bit       cfg_flag;
    metric_e  metric;
    in_beat_t beat;
  } pending_t;

  pending_t  pending_q[$];
  out_beat_t distance_q[$];

  // Predictor state, a shadow of the engine's accumulators.
  metric_e cur_metric = METRIC_EUCLID;
  longint  acc_main, acc_na, acc_nb;
  bit      acc_sat;
  bit      failed = 1'b0;
  bit      stim_done = 1'b0;
  bit      idle_enable = 1'b1;
  int      hold_cycles = 0;
  int      quiet_cycles = 0;
  bit      long_hold_go = 1'b0;
  bit      long_hold_used = 1'b0;
  int      long_hold_left = 0;

  function automatic longint clamp_sum(longint acc, longint add, longint lo, longint hi,
                                       ref bit sat);
    longint s;
    s = acc + add;
    if (s > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (s < lo) begin
      sat = 1'b1;
      return lo;
    end
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Fold one accepted element pair into the shadow sums; on the last element
  // push the expected distance beat and clear.
  task automatic accumulate_pair(in_beat_t beat);
    longint a, b, d, dist_v;
    longint unsigned ra, rb, den, mag, q, rem;
    bit zn;
    out_beat_t res;
    a = beat.a_element;
    b = beat.b_element;
    d = a - b;
    zn = 1'b0;
    dist_v = 0;
    case (cur_metric)
      METRIC_EUCLID, METRIC_SQ: acc_main = clamp_sum(acc_main, d * d, 0, SumCap, acc_sat);
      METRIC_MANH: acc_main = clamp_sum(acc_main, d < 0 ? -d : d, 0, SumCap, acc_sat);
      default: begin
        acc_main = clamp_sum(acc_main, a * b, -SumCap, SumCap, acc_sat);
        acc_na = clamp_sum(acc_na, a * a, 0, SumCap, acc_sat);
        acc_nb = clamp_sum(acc_nb, b * b, 0, SumCap, acc_sat);
      end
    endcase
    if (!beat.last_element) return;
    if (cur_metric == METRIC_EUCLID) begin
      dist_v = int_sqrt(acc_main);
    end else if (cur_metric != METRIC_COSINE) begin
      dist_v = acc_main;
    end else if (acc_na == 0 || acc_nb == 0) begin
      zn = 1'b1;
    end else begin
      ra = int_sqrt(longint'(acc_na) << 16);
      rb = int_sqrt(longint'(acc_nb) << 16);
      den = ra * rb;
      mag = acc_main < 0 ? -acc_main : acc_main;
      if (mag >= den) begin
        q = 65536;
      end else begin
        // Restoring division, 32 fraction bits; mag << 32 would not fit.
        rem = mag;
        q = 0;
        for (int i = 0; i < 32; i++) begin
          rem <<= 1;
          q <<= 1;
          if (rem >= den) begin
            rem -= den;
            q |= 1;
          end
        end
        if (q > 65536) q = 65536;
      end
      dist_v = acc_main < 0 ? -longint'(q) : longint'(q);
    end
    res.distance = dist_v[DistWidth-1:0];
    res.zero_norm = zn;
    res.saturated = acc_sat;
    distance_q.push_back(res);
    acc_main = 0;
    acc_na = 0;
    acc_nb = 0;
    acc_sat = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_metric(metric_e m);
    pending_t p;
    p.cfg_flag = 1'b1;
    p.metric = m;
    p.beat = '0;
    pending_q.push_back(p);
  endtask

  task automatic queue_pair(logic signed [15:0] a, logic signed [15:0] b, bit last);
    pending_t p;
    p.cfg_flag = 1'b0;
    p.metric = METRIC_EUCLID;
    p.beat.a_element = a;
    p.beat.b_element = b;
    p.beat.last_element = last;
    pending_q.push_back(p);
  endtask

  task automatic queue_vector(int len);
    for (int i = 0; i < len; i++) queue_pair(pick_elem(), pick_elem(), i == len - 1);
  endtask

  // Fill the stimulus: directed corners, saturation and a burst first, then random vectors.
  initial begin
    metric_e m;
    acc_main = 0;
    acc_na = 0;
    acc_nb = 0;
    acc_sat = 1'b0;
    // Reset metric is euclidean: extreme difference, single-element vectors.
    queue_pair(16'sh7fff, 16'sh8000, 1'b1);
    queue_pair(16'sh8000, 16'sh7fff, 1'b1);
    queue_pair('0, '0, 1'b1);
    for (int k = 0; k < 4; k++) begin
      m = metric_e'(k);
      queue_metric(m);
      queue_pair(16'sh7fff, 16'sh8000, 1'b0);
      queue_pair(16'sh0100, 16'sh0100, 1'b1);
      queue_pair(-16'sh0100, 16'sh0100, 1'b1);
    end
    // Cosine: zero norm on either side, and a parallel vector pair.
    queue_pair('0, 16'sh0100, 1'b1);
    queue_pair(16'sh0100, '0, 1'b1);
    queue_pair(16'sh8000, 16'sh8000, 1'b1);
    // Saturation: long vector of maximal terms in squared euclidean mode.
    queue_metric(METRIC_SQ);
    for (int i = 0; i < 1100; i++) begin
      if (i % 2 == 0) queue_pair(16'sh7fff, 16'sh8000, i == 1099);
      else queue_pair(16'sh8000, 16'sh7fff, i == 1099);
    end
    // Burst of short vectors offered while the receiver holds off.
    for (int i = 0; i < 30; i++) queue_pair(pick_elem(), pick_elem(), 1'b1);
    // Random part: runs of vectors per metric, mostly short.
    for (int n = 0; n < 200;) begin
      int len;
      queue_metric(metric_e'($urandom_range(0, 3)));
      repeat ($urandom_range(3, 12)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        queue_vector(len);
        n += len;
      end
    end
  end

  // Driver: element beats and metric writes, with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
        cur_metric <= metric_e'(cfg_data_i);
      end else if (in_valid_i && in_ready_o) begin
        accumulate_pair(in_data_i);
      end
      if ((in_valid_i && !in_ready_o) || (cfg_valid_i && !cfg_ready_o)) begin
        // Hold the current beat until it is accepted.
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_q[0].cfg_flag) begin
        in_valid_i <= 1'b0;
        // Metric writes go only into a drained engine, after a settle pause.
        if (quiet_cycles > 150) begin
          cfg_valid_i <= 1'b1;
          cfg_data_i <= pending_q[0].metric;
          pending_q.pop_front();
          quiet_cycles <= 0;
        end else if (distance_q.size() == 0 && !(in_valid_i && in_ready_o) && !out_valid_o) begin
          quiet_cycles <= quiet_cycles + 1;
        end else begin
          quiet_cycles <= 0;
        end
      end else if (idle_enable && $urandom_range(0, 99) < 24) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q[0].beat;
        pending_q.pop_front();
      end
    end
  end

  // Receiver side: random stalls, one long hold-off, and the checker.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (distance_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $realtime, out_data_o);
          failed = 1'b1;
        end else begin
          if (out_data_o !== distance_q[0]) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, distance_q[0],
                     out_data_o);
            failed = 1'b1;
          end
          void'(distance_q.pop_front());
        end
        // The saturated long vector is followed by the burst of short ones.
        if (out_data_o.saturated) long_hold_go = 1'b1;
      end
      hold_cycles <= hold_cycles + 1;
      if (long_hold_left > 0)
        out_ready_i <= 1'b0;
      else if (idle_enable && $urandom_range(0, 99) < 24)
        out_ready_i <= 1'b0;
      else
        out_ready_i <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering beats.
  always @(posedge clk_i) begin
    if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end else if (long_hold_go && !long_hold_used) begin
      long_hold_left <= 600;
      long_hold_used <= 1'b1;
    end
  end

  // A stretch without idling on either side.
  always @(posedge clk_i) begin
    if (hold_cycles == 1000) idle_enable <= 1'b0;
    if (hold_cycles == 1800) idle_enable <= 1'b1;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && distance_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (!failed && distance_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
